>>> design/fas_pkg.sv
// ----------------------------------------------------------------------------
// fas_pkg
// Types and codes shared by the frame animation sequencer.
// ----------------------------------------------------------------------------
package fas_pkg;

	localparam int TIME_W  = 24;
	localparam int FRAME_W = 16;
	localparam int COUNT_W = 7;
	localparam int INDEX_W = 6;

	typedef enum logic [1:0] {
		FUNC_TICK    = 2'd0,
		FUNC_LOAD    = 2'd1,
		FUNC_RESTART = 2'd2,
		FUNC_NOP     = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		KIND_SHOW = 2'd0,
		KIND_LOOP = 2'd1,
		KIND_END  = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TICK_CMP,
		ST_NEXT_CHK,
		ST_TGT_CHK,
		ST_RESTART_RD,
		ST_RESTART_CHK,
		ST_READ_OUT,
		ST_RESULT
	} state_t;

	typedef enum logic [1:0] {
		TOP_HOLD,
		TOP_STEP,
		TOP_CLEAR
	} timer_op_t;

	typedef struct packed {
		timer_op_t           op;
		logic [TIME_W-1:0]   amount;
		logic [TIME_W-1:0]   limit;
	} timer_cmd_t;

	typedef struct packed {
		logic [1:0]          kind;
		logic [FRAME_W-1:0]  value;
		logic [TIME_W-1:0]   duration;
	} entry_t;

	typedef struct packed {
		logic [1:0]          func;
		logic [TIME_W-1:0]   tick_amount;
		logic [INDEX_W-1:0]  entry_index;
		logic [1:0]          entry_kind;
		logic [FRAME_W-1:0]  entry_value;
		logic [TIME_W-1:0]   entry_duration;
	} cmd_item_t;

	typedef struct packed {
		logic [FRAME_W-1:0]  display_frame;
		logic                animation_done;
		logic                playing;
	} result_item_t;

	typedef logic [COUNT_W-1:0] cfg_word_t;

endpackage

>>> design/fas_stream_if.sv
// ----------------------------------------------------------------------------
// fas_stream_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface fas_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> design/fas_table.sv
// ----------------------------------------------------------------------------
// fas_table
// Command table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fas_table #(
	parameter int DEPTH = 64,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  fas_pkg::entry_t   wr_entry,
	input  logic [AW-1:0]     rd_addr,
	output fas_pkg::entry_t   rd_entry
);

	fas_pkg::entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_entry;
		end
	end

	always_ff @(posedge clk) begin
		rd_entry <= mem_q[rd_addr];
	end

endmodule

>>> design/fas_timer.sv
// ----------------------------------------------------------------------------
// fas_timer
// Frame timer with saturating accumulate and duration compare.
// ----------------------------------------------------------------------------
module fas_timer (
	input  logic                clk,
	input  logic                arst_n,
	input  fas_pkg::timer_cmd_t cmd,
	output logic                reached
);

	localparam int TW = fas_pkg::TIME_W;

	logic [TW-1:0] timer_q;
	logic [TW:0]   sum;
	logic [TW-1:0] sat;

	assign sum     = {1'b0, timer_q} + {1'b0, cmd.amount};
	assign sat     = sum[TW] ? {TW{1'b1}} : sum[TW-1:0];
	assign reached = (sat >= cmd.limit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q <= '0;
		end else begin
			case (cmd.op)
				fas_pkg::TOP_STEP:  timer_q <= reached ? '0 : sat;
				fas_pkg::TOP_CLEAR: timer_q <= '0;
				default:            timer_q <= timer_q;
			endcase
		end
	end

endmodule

>>> design/fas_ctrl.sv
// ----------------------------------------------------------------------------
// fas_ctrl
// Sequencer: takes items, walks the command table and drives the result.
// ----------------------------------------------------------------------------
module fas_ctrl #(
	parameter int TABLE_DEPTH = 64,
	parameter int AW          = $clog2(TABLE_DEPTH)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	fas_stream_if.sink            cmd,
	fas_stream_if.source          result,
	fas_stream_if.sink            cfg,
	output logic                  wr_en,
	output logic [AW-1:0]         wr_addr,
	output fas_pkg::entry_t       wr_entry,
	output logic [AW-1:0]         rd_addr,
	input  fas_pkg::entry_t       rd_entry,
	output fas_pkg::timer_cmd_t   tmr_cmd,
	input  logic                  tmr_reached
);

	localparam int PW = $clog2(TABLE_DEPTH + 1);
	localparam int KW = (PW > fas_pkg::COUNT_W) ? PW : fas_pkg::COUNT_W;
	localparam int FW = fas_pkg::FRAME_W;

	fas_pkg::state_t               state_q, state_d;
	logic [fas_pkg::TIME_W-1:0]    amount_q;
	logic [fas_pkg::COUNT_W-1:0]   count_q;
	logic [PW-1:0]                 pos_q, pos_d;
	logic [AW-1:0]                 cur_q, cur_d;
	logic [AW-1:0]                 tgt_q, tgt_d;
	logic                          has_q, has_d;
	logic                          done_q, done_d;
	logic                          out_valid_q;
	fas_pkg::result_item_t         out_data_q;
	logic                          out_load;
	logic                          accept;
	logic [KW-1:0]                 live;
	logic [KW-1:0]                 count_ext;
	logic [PW-1:0]                 pos_inc;

	assign accept    = cmd.valid && cmd.ready;
	assign count_ext = KW'(count_q);
	assign live      = (count_ext > KW'(TABLE_DEPTH)) ? KW'(TABLE_DEPTH) : count_ext;
	assign pos_inc   = (pos_q < PW'(TABLE_DEPTH)) ? pos_q + PW'(1) : pos_q;

	assign cfg.ready    = 1'b1;
	assign result.valid = out_valid_q;
	assign result.data  = out_data_q;

	assign wr_en    = accept && (cmd.data.func == fas_pkg::FUNC_LOAD)
		&& (32'(cmd.data.entry_index) < TABLE_DEPTH);
	assign wr_addr  = AW'(cmd.data.entry_index);
	assign wr_entry = '{kind: cmd.data.entry_kind, value: cmd.data.entry_value,
		duration: cmd.data.entry_duration};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fas_pkg::ST_IDLE;
			count_q     <= '0;
			pos_q       <= '0;
			cur_q       <= '0;
			tgt_q       <= '0;
			has_q       <= 1'b0;
			done_q      <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pos_q   <= pos_d;
			cur_q   <= cur_d;
			tgt_q   <= tgt_d;
			has_q   <= has_d;
			done_q  <= done_d;
			if (cfg.valid) begin
				count_q <= cfg.data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			amount_q <= cmd.data.tick_amount;
		end
		if (out_load) begin
			out_data_q.display_frame  <= has_q ? rd_entry.value : '0;
			out_data_q.animation_done <= done_q;
			out_data_q.playing        <= has_q;
		end
	end

	always_comb begin
		state_d        = state_q;
		pos_d          = pos_q;
		cur_d          = cur_q;
		tgt_d          = tgt_q;
		has_d          = has_q;
		done_d         = done_q;
		rd_addr        = cur_q;
		out_load       = 1'b0;
		cmd.ready      = 1'b0;
		tmr_cmd.op     = fas_pkg::TOP_HOLD;
		tmr_cmd.amount = amount_q;
		tmr_cmd.limit  = rd_entry.duration;

		unique case (state_q)
			fas_pkg::ST_IDLE: begin
				cmd.ready = 1'b1;
				if (cmd.valid) begin
					case (cmd.data.func)
						fas_pkg::FUNC_TICK:
							state_d = has_q ? fas_pkg::ST_TICK_CMP : fas_pkg::ST_RESULT;
						fas_pkg::FUNC_LOAD:    state_d = fas_pkg::ST_READ_OUT;
						fas_pkg::FUNC_RESTART: state_d = fas_pkg::ST_RESTART_RD;
						default:               state_d = fas_pkg::ST_RESULT;
					endcase
				end
			end
			fas_pkg::ST_TICK_CMP: begin
				tmr_cmd.op = fas_pkg::TOP_STEP;
				if (!tmr_reached) begin
					state_d = fas_pkg::ST_RESULT;
				end else begin
					pos_d = pos_inc;
					if (KW'(pos_inc) >= live) begin
						done_d  = 1'b1;
						state_d = fas_pkg::ST_RESULT;
					end else begin
						rd_addr = AW'(pos_inc);
						state_d = fas_pkg::ST_NEXT_CHK;
					end
				end
			end
			fas_pkg::ST_NEXT_CHK: begin
				case (rd_entry.kind)
					fas_pkg::KIND_SHOW: begin
						cur_d   = AW'(pos_q);
						state_d = fas_pkg::ST_READ_OUT;
					end
					fas_pkg::KIND_LOOP: begin
						if (rd_entry.value < FW'(live)) begin
							rd_addr = AW'(rd_entry.value);
							tgt_d   = AW'(rd_entry.value);
							state_d = fas_pkg::ST_TGT_CHK;
						end else begin
							state_d = fas_pkg::ST_RESTART_RD;
						end
					end
					fas_pkg::KIND_END: begin
						done_d  = 1'b1;
						state_d = fas_pkg::ST_RESULT;
					end
					default: state_d = fas_pkg::ST_RESULT;
				endcase
			end
			fas_pkg::ST_TGT_CHK: begin
				if (rd_entry.kind == fas_pkg::KIND_SHOW) begin
					pos_d   = PW'(tgt_q);
					cur_d   = tgt_q;
					state_d = fas_pkg::ST_READ_OUT;
				end else begin
					state_d = fas_pkg::ST_RESTART_RD;
				end
			end
			fas_pkg::ST_RESTART_RD: begin
				rd_addr    = '0;
				pos_d      = '0;
				done_d     = 1'b0;
				tmr_cmd.op = fas_pkg::TOP_CLEAR;
				state_d    = fas_pkg::ST_RESTART_CHK;
			end
			fas_pkg::ST_RESTART_CHK: begin
				rd_addr = '0;
				if (live == '0 || rd_entry.kind != fas_pkg::KIND_SHOW) begin
					has_d  = 1'b0;
					done_d = 1'b1;
				end else begin
					cur_d = '0;
					has_d = 1'b1;
				end
				state_d = fas_pkg::ST_RESULT;
			end
			fas_pkg::ST_READ_OUT: begin
				state_d = fas_pkg::ST_RESULT;
			end
			fas_pkg::ST_RESULT: begin
				if (!out_valid_q || result.ready) begin
					out_load = 1'b1;
					state_d  = fas_pkg::ST_IDLE;
				end
			end
			default: state_d = fas_pkg::ST_IDLE;
		endcase
	end

endmodule

>>> design/frame_animation_sequencer.sv
// Items are handled one at a time, from input transfer to the result register;
// the sequencer reads the current, next and loop-target entries through the single
// table read port.
// A new item is taken while the previous result still waits in its register.
// Reset (arst_n low) clears position, frame, timer and entry_count and sets done;
// the command table is not cleared.
// ----------------------------------------------------------------------------
// frame_animation_sequencer
// Plays a table of show-frame, loop and end commands against a frame timer.
// ----------------------------------------------------------------------------
module frame_animation_sequencer #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	fas_stream_if.sink    cmd,
	fas_stream_if.source  result,
	fas_stream_if.sink    cfg
);

	localparam int AW = $clog2(TABLE_DEPTH);

	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	fas_pkg::entry_t      wr_entry;
	logic [AW-1:0]        rd_addr;
	fas_pkg::entry_t      rd_entry;
	fas_pkg::timer_cmd_t  tmr_cmd;
	logic                 tmr_reached;

	fas_ctrl #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.AW          (AW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.result      (result),
		.cfg         (cfg),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_entry    (wr_entry),
		.rd_addr     (rd_addr),
		.rd_entry    (rd_entry),
		.tmr_cmd     (tmr_cmd),
		.tmr_reached (tmr_reached)
	);

	fas_table #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_table (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_entry (wr_entry),
		.rd_addr  (rd_addr),
		.rd_entry (rd_entry)
	);

	fas_timer u_timer (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (tmr_cmd),
		.reached (tmr_reached)
	);

endmodule

>>> design/fas_checker.sv
// ----------------------------------------------------------------------------
// fas_checker
// Port-level checks for the frame animation sequencer.
// ----------------------------------------------------------------------------
module fas_checker (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_valid,
	input  logic                   cmd_ready,
	input  logic                   res_valid,
	input  logic                   res_ready,
	input  fas_pkg::result_item_t  res_data
);

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped before transfer");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_data))
		else $error("stalled result changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.playing |-> res_data.display_frame == '0)
		else $error("frame shown while not playing");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("input taken while an item is in progress");

endmodule

bind frame_animation_sequencer fas_checker u_fas_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd.valid),
	.cmd_ready (cmd.ready),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_data  (result.data)
);
